[hdl/glu_pkg.sv]
// Package for the codepoint-to-glyph lookup: codes, widths, defaults and shared types.
package glu_pkg;

    // Field widths fixed by the interface.
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 12;
    localparam int CODE_W   = 21;
    localparam int ENTRY_W  = 16;
    localparam int COUNT_W  = 13;
    localparam int OUTC_W   = 2;

    // Defaults for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int ASCII_FIRST_DEF = 32;
    localparam int ASCII_LAST_DEF  = 126;

    localparam logic [CODE_W-1:0] REPLACEMENT_CODE = 21'h00FFFD;
    localparam logic [CODE_W-1:0] SPACE_CODE       = 21'd32;

    // Action codes carried on the input tuser.
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEAL   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Outcome codes carried on the output tuser.
    localparam logic [OUTC_W-1:0] OUT_EXACT   = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_REPLACE = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_SPACE   = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_NONE    = 2'd3;

    // Status returned by the search unit for one finished search.
    typedef struct packed {
        logic done;
        logic found;
    } search_res_t;

endpackage

[hdl/codepoint_glyph_lookup.sv]
// Top level of the codepoint-to-glyph lookup: sequencer, slot caches and stream ports.
// A load beat writes the code table directly; a sealed ASCII lookup reads its cached slot and
// then resolves; a table lookup runs k = ceil(log2(n+1)) probes over n live entries.
// A seal runs one search per ASCII code plus one for U+FFFD. One item is taken at a time:
// input is accepted only while idle, and all probes share the single code-table read port.
// Reset (async, active low) clears the count, the sealed flag and all slot valid bits;
// the code table itself is undefined until loaded.
module codepoint_glyph_lookup
    import glu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ASCII_FIRST = ASCII_FIRST_DEF,
    parameter int ASCII_LAST  = ASCII_LAST_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: live entry count register.
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,   // entry_slot[11:0], entry_code[27:12],
                                                  // codepoint[48:28], zero pad[55:49]
    input  logic [ACTION_W-1:0]   s_axis_tuser,   // action[1:0]
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // glyph_slot[11:0], zero pad[15:12]
    output logic [OUTC_W-1:0]     m_axis_tuser    // outcome[1:0]
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam bit HAS_ASCII = (ASCII_LAST >= ASCII_FIRST);
    localparam int ASCII_N   = HAS_ASCII ? (ASCII_LAST - ASCII_FIRST + 1) : 2;
    localparam int AIDX_W    = (ASCII_N > 1) ? $clog2(ASCII_N) : 1;
    localparam int ASCII_DEPTH = 1 << AIDX_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEAL_GO,
        S_SEAL_WAIT,
        S_REPL_GO,
        S_REPL_WAIT,
        S_LOOK_GO,
        S_LOOK_WAIT,
        S_ASC_READ,
        S_RESOLVE
    } state_t;

    // Unpacked input beat.
    logic [SLOT_W-1:0]   in_entry_slot;
    logic [ENTRY_W-1:0]  in_entry_code;
    logic [CODE_W-1:0]   in_codepoint;
    logic [ACTION_W-1:0] in_action;
    logic                in_beat;

    assign in_entry_slot = s_axis_tdata[11:0];
    assign in_entry_code = s_axis_tdata[27:12];
    assign in_codepoint  = s_axis_tdata[48:28];
    assign in_action     = s_axis_tuser;

    state_t                 state_reg;
    logic [COUNT_W-1:0]     entry_count_reg;
    logic                   sealed_reg;
    logic [CODE_W-1:0]      cp_reg;
    logic [6:0]             seal_code_reg;
    logic [AIDX_W-1:0]      asc_idx_reg;
    logic [ASCII_DEPTH-1:0] asc_valid_reg;
    logic                   repl_valid_reg;
    logic [SLOT_W-1:0]      repl_slot_reg;
    logic                   space_valid_reg;
    logic [SLOT_W-1:0]      space_slot_reg;
    logic                   hit_found_reg;
    logic [SLOT_W-1:0]      hit_slot_reg;
    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [OUTC_W-1:0]      out_kind_reg;

    // Live count: the register saturated at the table depth.
    logic [WIDE_W-1:0] count_wide;
    logic [CNT_W-1:0]  count_live;

    assign count_wide = WIDE_W'(entry_count_reg);
    assign count_live = (count_wide > WIDE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(count_wide);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Load beats write the code table directly; slots beyond the table are dropped.
    logic [31:0]      slot_wide;
    logic             load_we;
    logic [IDX_W-1:0] load_addr;

    assign slot_wide = 32'(in_entry_slot);
    assign load_we   = in_beat && (in_action == ACT_LOAD) && (slot_wide < 32'(TABLE_DEPTH));
    assign load_addr = slot_wide[IDX_W-1:0];

    // A lookup whose codepoint lies in the ASCII range reads the cached slot once sealed.
    logic              cp_in_ascii;
    logic [6:0]        cp_off;
    logic [AIDX_W-1:0] cp_idx;
    logic              asc_rd_en;

    assign cp_in_ascii = (in_codepoint >= CODE_W'(ASCII_FIRST)) &&
                         (in_codepoint <= CODE_W'(ASCII_LAST));
    assign cp_off      = in_codepoint[6:0] - 7'(ASCII_FIRST);
    assign cp_idx      = cp_off[AIDX_W-1:0];
    assign asc_rd_en   = in_beat && (in_action == ACT_LOOKUP) && sealed_reg && cp_in_ascii;

    // The seal pass walks the ASCII codes one search at a time.
    logic [6:0]        seal_off;
    logic [AIDX_W-1:0] seal_idx;

    assign seal_off = seal_code_reg - 7'(ASCII_FIRST);
    assign seal_idx = seal_off[AIDX_W-1:0];

    // Shared search unit and the code-table memory behind it.
    logic              search_start;
    logic [CODE_W-1:0] search_code;
    search_res_t       search_res;
    logic [IDX_W-1:0]  search_slot;
    logic [SLOT_W-1:0] search_slot_out;
    logic              tbl_rd_en;
    logic [IDX_W-1:0]  tbl_rd_addr;
    logic [ENTRY_W-1:0] tbl_rd_data;

    assign search_start    = (state_reg == S_SEAL_GO) || (state_reg == S_REPL_GO) ||
                             (state_reg == S_LOOK_GO);
    assign search_slot_out = SLOT_W'(32'(search_slot));

    always_comb
    begin
        unique case (state_reg)
            S_SEAL_GO: search_code = CODE_W'(seal_code_reg);
            S_REPL_GO: search_code = REPLACEMENT_CODE;
            default:   search_code = cp_reg;
        endcase
    end

    glu_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (search_start),
        .code    (search_code),
        .count   (count_live),
        .res     (search_res),
        .slot    (search_slot),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    glu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_code_table (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (load_addr),
        .wr_data (in_entry_code),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // Cached ASCII slots; their valid bits live in flip-flops so reset clears them at once.
    logic              asc_we;
    logic [SLOT_W-1:0] asc_rd_data;

    assign asc_we = (state_reg == S_SEAL_WAIT) && search_res.done;

    glu_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ASCII_DEPTH)
    ) u_ascii_slots (
        .clk     (clk),
        .wr_en   (asc_we),
        .wr_addr (seal_idx),
        .wr_data (search_slot_out),
        .rd_en   (asc_rd_en),
        .rd_addr (cp_idx),
        .rd_data (asc_rd_data)
    );

    // The output register is free when empty or when its beat leaves this cycle.
    logic out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            sealed_reg      <= 1'b0;
            cp_reg          <= '0;
            seal_code_reg   <= '0;
            asc_idx_reg     <= '0;
            asc_valid_reg   <= '0;
            repl_valid_reg  <= 1'b0;
            repl_slot_reg   <= '0;
            space_valid_reg <= 1'b0;
            space_slot_reg  <= '0;
            hit_found_reg   <= 1'b0;
            hit_slot_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_slot_reg    <= '0;
            out_kind_reg    <= OUT_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end

            // In the resolve state a leaving beat is replaced by the new result below.
            if (out_valid_reg && m_axis_tready && (state_reg != S_RESOLVE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        priority if (in_action == ACT_SEAL)
                        begin
                            seal_code_reg <= 7'(ASCII_FIRST);
                            state_reg     <= HAS_ASCII ? S_SEAL_GO : S_REPL_GO;
                        end
                        else if (in_action == ACT_LOOKUP)
                        begin
                            cp_reg      <= in_codepoint;
                            asc_idx_reg <= cp_idx;
                            state_reg   <= asc_rd_en ? S_ASC_READ : S_LOOK_GO;
                        end
                        else
                        begin
                            // Loads finish in this cycle; the unused action is dropped.
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_SEAL_GO:
                begin
                    state_reg <= S_SEAL_WAIT;
                end
                S_SEAL_WAIT:
                begin
                    if (search_res.done)
                    begin
                        asc_valid_reg[seal_idx] <= search_res.found;
                        if (CODE_W'(seal_code_reg) == SPACE_CODE)
                        begin
                            space_valid_reg <= search_res.found;
                            space_slot_reg  <= search_slot_out;
                        end
                        if (seal_code_reg == 7'(ASCII_LAST))
                        begin
                            state_reg <= S_REPL_GO;
                        end
                        else
                        begin
                            seal_code_reg <= seal_code_reg + 7'd1;
                            state_reg     <= S_SEAL_GO;
                        end
                    end
                end
                S_REPL_GO:
                begin
                    state_reg <= S_REPL_WAIT;
                end
                S_REPL_WAIT:
                begin
                    if (search_res.done)
                    begin
                        repl_valid_reg <= search_res.found;
                        repl_slot_reg  <= search_slot_out;
                        sealed_reg     <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_LOOK_GO:
                begin
                    state_reg <= S_LOOK_WAIT;
                end
                S_LOOK_WAIT:
                begin
                    if (search_res.done)
                    begin
                        hit_found_reg <= search_res.found;
                        hit_slot_reg  <= search_slot_out;
                        state_reg     <= S_RESOLVE;
                    end
                end
                S_ASC_READ:
                begin
                    // The slot memory read issued with the input beat is back now.
                    hit_found_reg <= asc_valid_reg[asc_idx_reg];
                    hit_slot_reg  <= asc_rd_data;
                    state_reg     <= S_RESOLVE;
                end
                S_RESOLVE:
                begin
                    // Fall back from the exact hit to the replacement glyph, then to space, then to none.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        priority if (hit_found_reg)
                        begin
                            out_slot_reg <= hit_slot_reg;
                            out_kind_reg <= OUT_EXACT;
                        end
                        else if (repl_valid_reg)
                        begin
                            out_slot_reg <= repl_slot_reg;
                            out_kind_reg <= OUT_REPLACE;
                        end
                        else if (space_valid_reg)
                        begin
                            out_slot_reg <= space_slot_reg;
                            out_kind_reg <= OUT_SPACE;
                        end
                        else
                        begin
                            out_slot_reg <= '0;
                            out_kind_reg <= OUT_NONE;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_slot_reg);
    assign m_axis_tuser  = out_kind_reg;

endmodule

[hdl/glu_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module glu_ram
    import glu_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/glu_search.sv]
// Lower-bound binary search over the code table; each probe reads an entry, then compares it.
module glu_search
    import glu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [CODE_W-1:0]              code,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
    output search_res_t                    res,
    output logic [$clog2(TABLE_DEPTH)-1:0] slot,
    output logic                           rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic [ENTRY_W-1:0]             rd_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        SR_IDLE,
        SR_PROBE,
        SR_CMP
    } sr_state_t;

    sr_state_t           state_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [CNT_W-1:0]    mid_reg;
    logic                eq_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                done_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    slot_reg;

    logic [CNT_W-1:0]    span;
    logic [CNT_W-1:0]    mid;
    logic                more;
    logic [CODE_W-1:0]   entry_wide;

    assign span       = hi_reg - lo_reg;
    assign mid        = lo_reg + (span >> 1);
    assign more       = lo_reg < hi_reg;
    assign entry_wide = CODE_W'(rd_data);

    assign rd_en   = (state_reg == SR_PROBE) && more;
    assign rd_addr = mid[IDX_W-1:0];

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign slot      = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SR_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
            eq_reg    <= 1'b0;
            code_reg  <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else
        begin
            // Done pulses for one cycle when a probe finds the range empty.
            done_reg <= (state_reg == SR_PROBE) && !more;
            unique case (state_reg)
                SR_IDLE:
                begin
                    if (start)
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= count;
                        eq_reg    <= 1'b0;
                        code_reg  <= code;
                        state_reg <= SR_PROBE;
                    end
                end
                SR_PROBE:
                begin
                    if (more)
                    begin
                        mid_reg   <= mid;
                        state_reg <= SR_CMP;
                    end
                    else
                    begin
                        // The final lower bound equals the last upper bound taken,
                        // so its equality flag tells whether the code is present.
                        found_reg <= eq_reg;
                        slot_reg  <= eq_reg ? lo_reg[IDX_W-1:0] : '0;
                        state_reg <= SR_IDLE;
                    end
                end
                SR_CMP:
                begin
                    if (entry_wide < code_reg)
                    begin
                        lo_reg <= mid_reg + CNT_W'(1);
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                        eq_reg <= (entry_wide == code_reg);
                    end
                    state_reg <= SR_PROBE;
                end
                default:
                begin
                    state_reg <= SR_IDLE;
                end
            endcase
        end
    end

endmodule

[dv/tb.sv]
// Testbench for codepoint_glyph_lookup: random and directed table loads, seals and lookups.
`timescale 1ns / 100ps

module tb;
    import glu_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 12;
    // A seal over a full table runs 96 searches, so a pass this long is enough for any seal
    // that can still be running after the last result has come out.
    localparam int QUIET_CYCLES = 3200;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_BEATS = 1000;

    // One input beat, as the predictor and the driver see it.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   entry_slot;
        logic [ENTRY_W-1:0]  entry_code;
        logic [CODE_W-1:0]   codepoint;
    } beat_t;

    // A precomputed slot with its valid flag.
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] at;
    } glyph_ref_t;

    // One expected result beat.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [OUTC_W-1:0] outcome;
    } glyph_pick_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [COUNT_W-1:0]  cfg_wdata;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [55:0]         s_axis_tdata;
    logic [ACTION_W-1:0] s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic [OUTC_W-1:0]   m_axis_tuser;

    beat_t cur_beat = '0;
    beat_t next_beat;
    logic  beat_taken = 1'b0;

    // Stimulus side: beats waiting for the driver, and the table as the generator laid it out.
    beat_t          pending_beats[$];
    logic [15:0]    gen_tbl[0:TABLE_DEPTH_DEF-1];
    int             gen_live = 0;
    int             beats_queued = 0;
    int             beats_taken = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_asked = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    // Predictor state: its own copy of the table, the slot caches, the flag and the count.
    logic [15:0]    code_copy[0:TABLE_DEPTH_DEF-1];
    glyph_ref_t     ascii_copy[0:ASCII_LAST_DEF-ASCII_FIRST_DEF];
    glyph_ref_t     repl_copy;
    logic           sealed_copy;
    int unsigned    count_copy;
    glyph_pick_t    expected_picks[$];

    // Bookkeeping for the summary.
    int             cycle_cnt = 0;
    int             mismatches = 0;
    int             outcome_seen[4];
    int             loads_seen = 0;
    int             seals_seen = 0;
    int             lookups_seen = 0;
    int             ignored_seen = 0;
    int             settings_made = 0;

    // Stream packing: tdata carries entry_slot, entry_code and codepoint from bit 0 up.
    assign s_axis_tdata = {7'b0, cur_beat.codepoint, cur_beat.entry_code, cur_beat.entry_slot};
    assign s_axis_tuser = cur_beat.action;

    codepoint_glyph_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Lower-bound binary search over the live part of the table. The count saturates at the
    // table depth, and a hit needs the entry found to equal the full 21-bit codepoint.
    function automatic glyph_ref_t glyph_search(input logic [CODE_W-1:0] cp);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        glyph_ref_t  found;
        n  = (count_copy > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : count_copy;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if ({5'b0, code_copy[mid]} < cp)
                lo = mid + 1;
            else
                hi = mid;
        end
        found.ok = (lo < n) && ({5'b0, code_copy[lo]} == cp);
        found.at = found.ok ? SLOT_W'(lo) : '0;
        return found;
    endfunction

    function automatic bit is_ascii(input logic [CODE_W-1:0] cp);
        return cp >= ASCII_FIRST_DEF && cp <= ASCII_LAST_DEF;
    endfunction

    // Applies one accepted beat to the predictor state and queues the result it causes.
    task automatic predict_beat(input beat_t b);
        glyph_ref_t  hit;
        glyph_pick_t pick;
        int          c;
        case (b.action)
            ACT_LOAD:
            begin
                code_copy[b.entry_slot] = b.entry_code;
                loads_seen++;
            end
            ACT_SEAL:
            begin
                // A seal always rebuilds every cached slot from the current table.
                for (c = ASCII_FIRST_DEF; c <= ASCII_LAST_DEF; c++)
                    ascii_copy[c - ASCII_FIRST_DEF] = glyph_search(CODE_W'(c));
                repl_copy   = glyph_search(REPLACEMENT_CODE);
                sealed_copy = 1'b1;
                seals_seen++;
            end
            ACT_LOOKUP:
            begin
                if (sealed_copy && is_ascii(b.codepoint))
                    hit = ascii_copy[b.codepoint - ASCII_FIRST_DEF];
                else
                    hit = glyph_search(b.codepoint);
                // Fallback chain: exact, then replacement glyph, then space glyph, then none.
                if (hit.ok)
                    pick = '{slot: hit.at, outcome: OUT_EXACT};
                else if (repl_copy.ok)
                    pick = '{slot: repl_copy.at, outcome: OUT_REPLACE};
                else if (ascii_copy[SPACE_CODE - ASCII_FIRST_DEF].ok)
                    pick = '{slot: ascii_copy[SPACE_CODE - ASCII_FIRST_DEF].at,
                             outcome: OUT_SPACE};
                else
                    pick = '{slot: '0, outcome: OUT_NONE};
                expected_picks.push_back(pick);
                lookups_seen++;
            end
            default:
                ignored_seen++;
        endcase
    endtask

    task automatic check_result(input logic [SLOT_W-1:0] got_slot,
                                input logic [OUTC_W-1:0] got_outcome);
        glyph_pick_t want;
        if (expected_picks.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result: expected nothing, got glyph_slot %0d outcome %0d",
                     $time, got_slot, got_outcome);
        end
        else
        begin
            want = expected_picks.pop_front();
            outcome_seen[want.outcome]++;
            if (got_outcome !== want.outcome)
            begin
                mismatches++;
                $display("%0t: outcome mismatch: expected %0d, got %0d",
                         $time, want.outcome, got_outcome);
            end
            if (got_slot !== want.slot)
            begin
                mismatches++;
                $display("%0t: glyph_slot mismatch: expected %0d, got %0d",
                         $time, want.slot, got_slot);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both streams at the rising edge. Results are checked before the
    // input beat of the same edge is predicted, so a result can never match its own beat.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        beat_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            cycle_cnt++;
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata[SLOT_W-1:0], m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_beat(cur_beat);
                beats_taken++;
            end
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles, %0d results still expected",
                         $time, cycle_cnt, expected_picks.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the next pending beat at the falling edge, with random gaps.
    // A beat stays on the bus until the edge that accepts it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || beat_taken)
        begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_beat = pending_beats.pop_front();
                cur_beat      <= next_beat;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so that the block backs up
    // and stops taking input while the driver keeps offering beats.
    always @(negedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen     <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [ACTION_W-1:0] act, input int unsigned slot,
                             input int unsigned code, input int unsigned cp);
        beat_t b;
        b.action     = act;
        b.entry_slot = SLOT_W'(slot);
        b.entry_code = ENTRY_W'(code);
        b.codepoint  = CODE_W'(cp);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // Fields that an action does not use are filled at random; the block must ignore them.
    task automatic push_load(input int unsigned slot, input int unsigned code);
        gen_tbl[slot] = ENTRY_W'(code);
        push_beat(ACT_LOAD, slot, code, $urandom_range(0, 21'h10FFFF));
    endtask

    task automatic push_seal();
        push_beat(ACT_SEAL, $urandom_range(0, 4095), $urandom_range(0, 16'hFFFF),
                  $urandom_range(0, 21'h10FFFF));
    endtask

    task automatic push_lookup(input int unsigned cp);
        push_beat(ACT_LOOKUP, $urandom_range(0, 4095), $urandom_range(0, 16'hFFFF), cp);
    endtask

    // Codepoints aimed at hits, near misses, the ASCII range, the replacement character, random
    // 16-bit codes and codes above the 16-bit table range.
    function automatic int unsigned pick_codepoint();
        int unsigned r;
        int unsigned i;
        r = $urandom_range(0, 99);
        if (r < 30 && gen_live > 0)
            return gen_tbl[$urandom_range(0, gen_live - 1)];
        if (r < 40 && gen_live > 0)
        begin
            i = gen_tbl[$urandom_range(0, gen_live - 1)];
            return ($urandom_range(0, 1) == 1 || i == 0) ? i + 1 : i - 1;
        end
        if (r < 60)
            return $urandom_range(ASCII_FIRST_DEF - 1, ASCII_LAST_DEF + 1);
        if (r < 68)
            return REPLACEMENT_CODE;
        if (r < 84)
            return $urandom_range(0, 16'hFFFF);
        return $urandom_range(21'h10000, 21'h10FFFF);
    endfunction

    // Register writes happen only with the block idle, so the predictor copy is set directly.
    task automatic write_count(input int unsigned value);
        @(negedge clk);
        cfg_we        = 1'b1;
        cfg_wdata     = COUNT_W'(value);
        count_copy    = value;
        gen_live      = (value > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : value;
        settings_made++;
        @(negedge clk);
        cfg_we        = 1'b0;
    endtask

    // Waits until every beat is in and every result out, then lets a trailing seal finish.
    task automatic settle();
        while (beats_taken != beats_queued || expected_picks.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    // Builds a nondecreasing table of n codes and loads it, forward or backward. Whether it
    // holds ASCII codes, the space and the replacement character is chosen at random, and
    // now and then a code repeats so that the lower-bound search meets duplicates.
    task automatic load_sorted_table(input int n);
        int unsigned cur;
        int unsigned lim;
        int unsigned stride;
        int          i;
        bit          with_ascii;
        bit          with_space;
        bit          with_repl;
        bit          backwards;
        with_ascii = ($urandom_range(0, 3) != 0);
        with_space = ($urandom_range(0, 3) != 0);
        with_repl  = ($urandom_range(0, 1) == 1);
        backwards  = ($urandom_range(0, 1) == 1);
        lim = with_repl ? 16'hFFFC : 16'hFFFF;
        cur = with_ascii ? $urandom_range(28, 40) : $urandom_range(0, 20);
        for (i = 0; i < n; i++)
        begin
            if (with_repl && i == n - 1)
                cur = REPLACEMENT_CODE;
            else
            begin
                if (!with_ascii && is_ascii(CODE_W'(cur)))
                    cur = ASCII_LAST_DEF + 1 + $urandom_range(0, 40);
                if (!with_space && cur == SPACE_CODE)
                    cur++;
                if (cur > lim)
                    cur = lim;
            end
            gen_tbl[i] = ENTRY_W'(cur);
            if ($urandom_range(0, 19) == 0)
                stride = 0;
            else if (with_ascii && cur <= ASCII_LAST_DEF)
                stride = $urandom_range(1, 3);
            else
                stride = $urandom_range(1, 2 * (lim - cur) / (n - i) + 1);
            cur = cur + stride;
        end
        for (i = 0; i < n; i++)
            push_load(backwards ? n - 1 - i : i, gen_tbl[backwards ? n - 1 - i : i]);
    endtask

    // One phase: set the count, lay out a fresh table (n of zero keeps the old one), usually
    // seal it, then mostly lookups with ignored actions, stray loads and reseals mixed in.
    task automatic run_phase(input int n, input int unsigned cnt, input int mode,
                             input int lookups, input bit long_hold);
        int          i;
        int unsigned r;
        int unsigned spare;
        set_idling(mode);
        write_count(cnt);
        if (n > 0)
            load_sorted_table(n);
        if (n >= TABLE_DEPTH_DEF || $urandom_range(0, 9) < 7)
            push_seal();
        if (long_hold)
            hold_asked++;
        // Stray loads only touch entries above both the loaded and the live part.
        spare = (n > gen_live) ? n : gen_live;
        for (i = 0; i < lookups; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                push_beat(ACT_UNUSED, $urandom_range(0, 4095),
                          $urandom_range(0, 16'hFFFF), $urandom_range(0, 21'h10FFFF));
            else if (r < 10 && spare < TABLE_DEPTH_DEF)
                push_load($urandom_range(spare, TABLE_DEPTH_DEF - 1),
                          $urandom_range(0, 16'hFFFF));
            else if (r < 14)
                push_seal();
            else
                push_lookup(pick_codepoint());
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;
        int unsigned cnt;
        int rand_start;
        int bulk;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        count_copy    = 0;
        sealed_copy   = 1'b0;
        repl_copy     = '0;
        foreach (ascii_copy[i])
            ascii_copy[i] = '0;
        foreach (outcome_seen[i])
            outcome_seen[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: lookups at both ends of the codepoint range, an unused action with all slot
        // and code bits set and codepoint U+10FFFF, and a seal that leaves every cached slot invalid.
        push_lookup(0);
        push_lookup(21'h10FFFF);
        push_beat(ACT_UNUSED, 4095, 16'hFFFF, 21'h10FFFF);
        push_seal();
        push_lookup("A");
        settle();

        // Six entries loaded backward, covering code 0, the space, 'A', U+FFFD and U+FFFF.
        // The old seal is still in force, so 'A' has no valid slot and finds nothing.
        write_count(6);
        push_load(5, 16'hFFFF);
        push_load(4, REPLACEMENT_CODE);
        push_load(3, 16'h7FFF);
        push_load(2, "A");
        push_load(1, SPACE_CODE);
        push_load(0, 0);
        push_lookup("A");
        push_lookup(16'hFFFF);
        push_lookup(0);
        push_seal();
        push_lookup("A");
        push_lookup("B");
        push_lookup(21'h10000);
        // A load after a seal leaves the cached replacement slot as it was.
        push_load(4, 16'hFFFE);
        push_lookup(REPLACEMENT_CODE);
        settle();

        // Shrink the live part so the replacement character drops out and the space glyph
        // becomes the fallback.
        write_count(3);
        push_seal();
        push_lookup("B");
        push_lookup(16'hFFFF);
        settle();

        // Random phases. Phase 1 carries the long receiver hold-off, phase 3 fills the whole
        // table and phase 4 reuses it with a count far above the depth.
        phase      = 0;
        bulk       = 0;
        rand_start = beats_queued;
        while (beats_queued - rand_start - bulk < RANDOM_BEATS)
        begin
            if (phase == 3)
            begin
                bulk = TABLE_DEPTH_DEF;
                run_phase(TABLE_DEPTH_DEF, TABLE_DEPTH_DEF, phase % 4, 40, 1'b0);
            end
            else if (phase == 4)
                run_phase(0, (1 << COUNT_W) - 1, phase % 4, 40, 1'b0);
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: n = $urandom_range(0, 12);
                    5, 6, 7:       n = $urandom_range(13, 64);
                    default:       n = $urandom_range(65, 300);
                endcase
                if (phase == 1)
                    n = 8;
                cnt = n;
                if ($urandom_range(0, 19) < 3)
                    cnt = $urandom_range(0, n);
                run_phase(n, cnt, phase % 4, $urandom_range(15, 40), phase == 1);
            end
            phase++;
        end

        $display("Covered %0d beats: %0d loads, %0d seals, %0d lookups, %0d ignored, %0d counts.",
                 beats_taken, loads_seen, seals_seen, lookups_seen, ignored_seen, settings_made);
        $display("Results: %0d exact, %0d replacement, %0d space, %0d none; %0d mismatches.",
                 outcome_seen[OUT_EXACT], outcome_seen[OUT_REPLACE], outcome_seen[OUT_SPACE],
                 outcome_seen[OUT_NONE], mismatches);
        if (mismatches == 0 && expected_picks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
